@@ sv/bvam_pkg.sv @@
package bvam_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int OP_W = 2;
  localparam int SYM_W = 8;
  localparam int DIST_W = 7;
  localparam int POS_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [DIST_W-1:0] MAXD_RESET = 7'd2;
  localparam logic [DIST_W-1:0] DIST_SAT = 7'd127;

  localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_TEXT = 2'd2;

  typedef enum logic {
    CMD_RESTART = 1'b0,
    CMD_TEXT = 1'b1
  } cmd_t;

endpackage

@@ sv/bvam_req_if.sv @@
interface bvam_req_if;
  logic valid;
  logic ready;
  logic [bvam_pkg::OP_W-1:0] operation;
  logic [bvam_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink (input valid, input operation, input symbol, output ready);
endinterface

@@ sv/bvam_res_if.sv @@
interface bvam_res_if;
  logic valid;
  logic ready;
  logic [bvam_pkg::DIST_W-1:0] distance;
  logic match;
  logic [bvam_pkg::POS_W-1:0] text_position;

  modport source (output valid, output distance, output match, output text_position,
                  input ready);
  modport sink (input valid, input distance, input match, input text_position,
                output ready);
endinterface

@@ sv/bvam_front.sv @@
module bvam_front #(
  parameter int MAX_PATTERN = bvam_pkg::MAX_PATTERN_DEF,
  parameter int LW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  bvam_req_if.sink               in_req,
  input  logic                   push_ready,
  output logic                   push_valid,
  output bvam_pkg::cmd_t         push_cmd,
  output logic [MAX_PATTERN-1:0] push_eq,
  output logic [LW-1:0]          push_len
);
  import bvam_pkg::*;

  localparam int W = MAX_PATTERN;
  localparam int IW = (W > 1) ? $clog2(W) : 1;

  logic [SYM_W-1:0] pat_r [W];
  logic [LW-1:0] len_r, len_nxt;
  logic accept;
  logic room;
  logic [W-1:0] eq;

  assign in_req.ready = push_ready;
  assign accept = in_req.valid && push_ready;
  assign room = (len_r < LW'(W));

  always_comb begin
    for (int i = 0; i < W; i++) begin
      eq[i] = (pat_r[i] == in_req.symbol) && (LW'(i) < len_r);
    end
  end

  always_comb begin
    len_nxt = len_r;
    push_valid = 1'b0;
    push_cmd = CMD_RESTART;
    unique case (in_req.operation)
      OP_BEGIN: begin
        len_nxt = '0;
        push_valid = accept;
      end
      OP_PATTERN: begin
        if (room) begin
          len_nxt = len_r + LW'(1);
        end
        push_valid = accept;
      end
      OP_TEXT: begin
        push_valid = accept;
        push_cmd = CMD_TEXT;
      end
      default: begin
        push_valid = 1'b0;
      end
    endcase
  end

  assign push_eq = eq;
  assign push_len = len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept) begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_req.operation == OP_PATTERN) && room) begin
      pat_r[len_r[IW-1:0]] <= in_req.symbol;
    end
  end

`ifndef ASSERT_OFF
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(W))
    else $error("pattern length beyond capacity");
  a_begin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.operation == OP_BEGIN) |=> (len_r == '0))
    else $error("begin did not clear pattern length");
  a_text_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.operation == OP_TEXT) |=> $stable(len_r))
    else $error("text request changed pattern length");
`endif
endmodule

@@ sv/bvam_fifo.sv @@
module bvam_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH = bvam_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push = push && push_ready;
  assign do_pop = pop && pop_valid;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r != '0))
    else $error("queue empty after push");
  a_ptr_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with unequal pointers");
`endif
endmodule

@@ sv/bvam_back.sv @@
module bvam_back #(
  parameter int MAX_PATTERN = bvam_pkg::MAX_PATTERN_DEF,
  parameter int LW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bvam_pkg::DIST_W-1:0]   cfg_wdata,
  input  logic                          pop_valid,
  input  bvam_pkg::cmd_t                pop_cmd,
  input  logic [MAX_PATTERN-1:0]        pop_eq,
  input  logic [LW-1:0]                 pop_len,
  output logic                          pop,
  bvam_res_if.source                    out_res
);
  import bvam_pkg::*;

  localparam int W = MAX_PATTERN;
  localparam int IW = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] pv_r, mv_r, pv_nxt, mv_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt, maxd_r;
  logic [POS_W-1:0] pos_r;
  logic out_valid_r, out_match_r;
  logic [DIST_W-1:0] out_dist_r;
  logic [POS_W-1:0] out_pos_r;
  logic [W-1:0] xv, xh, ph, mh, ph_s, mh_s;
  logic [IW-1:0] top;
  logic pop_text, pop_restart;

  assign pop = pop_valid && ((pop_cmd == CMD_RESTART) || !out_valid_r || out_res.ready);
  assign pop_text = pop && (pop_cmd == CMD_TEXT);
  assign pop_restart = pop && (pop_cmd == CMD_RESTART);

  always_comb begin
    xv = pop_eq | mv_r;
    xh = (((pop_eq & pv_r) + pv_r) ^ pv_r) | pop_eq;
    ph = mv_r | ~(xh | pv_r);
    mh = pv_r & xh;
    top = IW'(pop_len - LW'(1));
    ph_s = ph << 1;
    mh_s = mh << 1;
    pv_nxt = pv_r;
    mv_nxt = mv_r;
    dist_nxt = '0;
    if (pop_len != '0) begin
      pv_nxt = mh_s | ~(xv | ph_s);
      mv_nxt = ph_s & xv;
      dist_nxt = dist_r;
      if (ph[top]) begin
        if (dist_r < DIST_SAT) begin
          dist_nxt = dist_r + DIST_W'(1);
        end
      end else if (mh[top]) begin
        if (dist_r != '0) begin
          dist_nxt = dist_r - DIST_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '1;
      mv_r <= '0;
      dist_r <= '0;
      pos_r <= '0;
      maxd_r <= MAXD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        maxd_r <= cfg_wdata;
      end
      if (pop_restart) begin
        pv_r <= '1;
        mv_r <= '0;
        dist_r <= DIST_W'(pop_len);
        pos_r <= '0;
      end else if (pop_text) begin
        pv_r <= pv_nxt;
        mv_r <= mv_nxt;
        dist_r <= dist_nxt;
        pos_r <= pos_r + POS_W'(1);
      end
      if (pop_text) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_text) begin
      out_dist_r <= dist_nxt;
      out_match_r <= (dist_nxt <= maxd_r);
      out_pos_r <= pos_r;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.distance = out_dist_r;
  assign out_res.match = out_match_r;
  assign out_res.text_position = out_pos_r;

`ifndef ASSERT_OFF
  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pop_restart |=> (pos_r == '0) && (dist_r == DIST_W'($past(pop_len))))
    else $error("restart did not reset search state");
  a_empty_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_text && pop_len == '0) |=> (out_dist_r == '0) && out_valid_r)
    else $error("empty pattern gave nonzero distance");
  a_text_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop_text |=> (out_pos_r == $past(pos_r)) && (pos_r == $past(pos_r) + POS_W'(1)))
    else $error("text position did not advance");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res.ready) |-> !pop_text)
    else $error("pending result overwritten");
`endif
endmodule

@@ sv/bit_vector_approximate_matcher_core.sv @@
// bit-parallel approximate matcher, pattern up to MAX_PATTERN bytes
// in_req: requests of operation and symbol, taken when valid and ready are high
//   begin clears the pattern, pattern symbol appends one byte unless full and
//   restarts the search, text symbol produces one result, unused code is dropped
// out_res: distance, match and text_position, one per text request
// cfg_we / cfg_wdata: write of the match threshold, reset value 2
// a text request is queued, then its result is registered in the back end
// throughput: one request per cycle while results are taken, set by the vector update
//   (one MAX_PATTERN-bit add) in the back end
// the front end compares a text byte with every stored pattern byte in the
//   cycle it is taken and queues the match mask in a two-entry queue
// reset (rst_n low, synchronous): empty pattern, vectors to start values,
//   position 0, threshold 2, no result pending
// receiver stall: the result register holds; restarts still drain the queue,
//   and the queue fills and drops in_req.ready after two more requests
module bit_vector_approximate_matcher_core #(
  parameter int MAX_PATTERN = bvam_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bvam_req_if.sink                    in_req,
  bvam_res_if.source                  out_res,
  input  logic                        cfg_we,
  input  logic [bvam_pkg::DIST_W-1:0] cfg_wdata
);
  import bvam_pkg::*;

  localparam int W = MAX_PATTERN;
  localparam int LW = $clog2(W + 1);
  localparam int QW = 1 + W + LW;

  logic push_valid, push_ready, pop, pop_valid;
  cmd_t push_cmd, pop_cmd;
  logic [W-1:0] push_eq, pop_eq;
  logic [LW-1:0] push_len, pop_len;
  logic [QW-1:0] pop_data;

  bvam_front #(.MAX_PATTERN(W), .LW(LW)) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(in_req),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_cmd(push_cmd),
    .push_eq(push_eq),
    .push_len(push_len)
  );

  bvam_fifo #(.DATA_W(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push_valid),
    .push_data({push_cmd, push_eq, push_len}),
    .push_ready(push_ready),
    .pop(pop),
    .pop_valid(pop_valid),
    .pop_data(pop_data)
  );

  assign pop_cmd = cmd_t'(pop_data[QW-1]);
  assign pop_eq = pop_data[QW-2:LW];
  assign pop_len = pop_data[LW-1:0];

  bvam_back #(.MAX_PATTERN(W), .LW(LW)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .pop_valid(pop_valid),
    .pop_cmd(pop_cmd),
    .pop_eq(pop_eq),
    .pop_len(pop_len),
    .pop(pop),
    .out_res(out_res)
  );
endmodule
